// ----- rtl/dmam_pkg.sv -----
package dmam_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int WINDOW_DEF   = 8;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] temp_sample;
    logic signed [SAMPLE_BITS-1:0] charge_sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] temp_min;
    logic signed [SAMPLE_BITS-1:0] temp_max;
    logic signed [SAMPLE_BITS-1:0] temp_avg;
    logic signed [SAMPLE_BITS-1:0] charge_min;
    logic signed [SAMPLE_BITS-1:0] charge_max;
    logic signed [SAMPLE_BITS-1:0] charge_avg;
  } out_t;

endpackage

// ----- rtl/dmam_ram.sv -----
module dmam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/dmam_chan.sv -----
module dmam_chan #(
  parameter int WINDOW = dmam_pkg::WINDOW_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic signed [dmam_pkg::SAMPLE_BITS-1:0] x,
  input  logic signed [dmam_pkg::SAMPLE_BITS-1:0] old,
  output logic signed [dmam_pkg::SAMPLE_BITS-1:0] new_min,
  output logic signed [dmam_pkg::SAMPLE_BITS-1:0] new_max,
  output logic signed [dmam_pkg::SAMPLE_BITS-1:0] new_avg
);
  import dmam_pkg::*;

  localparam int  SUM_W = SAMPLE_BITS + $clog2(WINDOW);
  localparam bit  POW2  = (WINDOW & (WINDOW - 1)) == 0;

  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic signed [SAMPLE_BITS-1:0] min_r, max_r;

  assign sum_nxt = sum_r + SUM_W'(x) - SUM_W'(old);
  assign new_min = (x < min_r) ? x : min_r;
  assign new_max = (x > max_r) ? x : max_r;

  generate
    if (POW2) begin : g_shift
      logic signed [SUM_W-1:0] q;
      assign q       = sum_nxt >>> $clog2(WINDOW);
      assign new_avg = q[SAMPLE_BITS-1:0];
    end else begin : g_recip
      // floor(s/W): bias s to non-negative, multiply by ceil(2^K/W), drop the bias
      localparam int N   = SUM_W + 1;
      localparam int K   = N + $clog2(WINDOW);
      localparam int MW  = N + 1;
      localparam longint unsigned MUL_L = ((64'd1 << K) + WINDOW - 1) / WINDOW;
      localparam logic [MW-1:0] MUL  = MW'(MUL_L);
      localparam logic [N-1:0]  BIAS = N'(WINDOW) << (SAMPLE_BITS - 1);
      logic [N-1:0]    u;
      logic [N+MW-1:0] prod;
      logic [N+MW-1:0] q;
      assign u    = N'(sum_nxt) + BIAS;
      assign prod = (N+MW)'(u) * (N+MW)'(MUL);
      assign q    = prod >> K;
      // subtracting 2^(SAMPLE_BITS-1) modulo the field width flips the top bit
      assign new_avg = {~q[SAMPLE_BITS-1], q[SAMPLE_BITS-2:0]};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      min_r <= '0;
      max_r <= '0;
    end else if (en) begin
      sum_r <= sum_nxt;
      min_r <= new_min;
      max_r <= new_max;
    end
  end

endmodule

// ----- rtl/dual_moving_average_min_max_top.sv -----
// Channel   Ports                         Direction  Transaction
// in        in_valid, in_stall, in_data    input      one temp/charge sample pair
// out       out_valid, out_stall, out_data output     min, max, avg for both channels
//
// Throughput: one transaction per cycle while out_stall is low; an accepted pair passes
// the read stage (s1 registers and registered window RAM read), then the result register.
// Reset (synchronous, rst_n low) clears the write pointer, the fill flag, the sums and
// the extremes; the RAM is not swept, entries read before their first write count as 0.
// Out stall holds the result register; input stalls only while a result is held and
// the read stage is also full.
module dual_moving_average_min_max_top #(
  parameter int WINDOW = dmam_pkg::WINDOW_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  dmam_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output dmam_pkg::out_t out_data
);
  import dmam_pkg::*;

  localparam int PW = $clog2(WINDOW);
  localparam int RW = 2 * SAMPLE_BITS;

  logic          in_acc, advance;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          seen_r, seen_nxt;
  logic          s1_valid_r;
  in_t           s1_data_r;
  logic [PW-1:0] s1_pos_r;
  logic          s1_seen_r;
  logic          out_valid_r;
  out_t          out_data_r, res;
  logic [RW-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] old_temp, old_charge;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  assign pos_nxt  = (pos_r == PW'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
  // once the pointer has wrapped, every entry read has been written
  assign seen_nxt = seen_r || (pos_r == PW'(WINDOW - 1));

  dmam_ram #(.WIDTH(RW), .DEPTH(WINDOW)) u_ram (
    .clk     (clk),
    .wr_en   (advance),
    .wr_addr (s1_pos_r),
    .wr_data ({s1_data_r.charge_sample, s1_data_r.temp_sample}),
    .rd_en   (in_acc),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  assign old_temp   = s1_seen_r ? rd_data[SAMPLE_BITS-1:0]  : '0;
  assign old_charge = s1_seen_r ? rd_data[RW-1:SAMPLE_BITS] : '0;

  dmam_chan #(.WINDOW(WINDOW)) u_temp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .x       (s1_data_r.temp_sample),
    .old     (old_temp),
    .new_min (res.temp_min),
    .new_max (res.temp_max),
    .new_avg (res.temp_avg)
  );

  dmam_chan #(.WINDOW(WINDOW)) u_charge (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .x       (s1_data_r.charge_sample),
    .old     (old_charge),
    .new_min (res.charge_min),
    .new_max (res.charge_max),
    .new_avg (res.charge_avg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      seen_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        pos_r  <= pos_nxt;
        seen_r <= seen_nxt;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
      s1_pos_r  <= pos_r;
      s1_seen_r <= seen_r;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/dmam_checker.sv -----
module dmam_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input dmam_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input dmam_pkg::out_t out_data
);
  import dmam_pkg::*;

  // no result may appear straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input backs up only when a result is held at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // extremes start at zero and the window average lies between them
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.temp_min <= 0 && out_data.temp_max >= 0 &&
                  out_data.temp_avg >= out_data.temp_min &&
                  out_data.temp_avg <= out_data.temp_max &&
                  out_data.charge_min <= 0 && out_data.charge_max >= 0 &&
                  out_data.charge_avg >= out_data.charge_min &&
                  out_data.charge_avg <= out_data.charge_max)
    else $error("result fields out of order");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted transaction produced no result");

endmodule

bind dual_moving_average_min_max_top dmam_checker u_dmam_checker (.*);

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmam_pkg::*;

  localparam int AVG_DEPTH = WINDOW_DEF;

  // Running min/max and window average for both channels (0 = temp, 1 = charge).
  class min_max_avg_tracker;
    int hist [2][AVG_DEPTH];
    int total [2];
    int lo [2];
    int hi [2];
    int slot;
    out_t expected_stats[$];
    int mismatch_count;

    function new();
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < AVG_DEPTH; i++) hist[c][i] = 0;
        total[c] = 0;
        lo[c] = 0;
        hi[c] = 0;
      end
      slot = 0;
      mismatch_count = 0;
    endfunction

    function int floor_avg(int s);
      int q;
      q = s / AVG_DEPTH;
      if ((s % AVG_DEPTH) != 0 && s < 0) q -= 1;
      return q;
    endfunction

    function int update_channel(int c, int x);
      total[c] += x - hist[c][slot];
      hist[c][slot] = x;
      if (x < lo[c]) lo[c] = x;
      if (x > hi[c]) hi[c] = x;
      return floor_avg(total[c]);
    endfunction

    function void take_sample(in_t s);
      out_t e;
      int t_avg;
      int c_avg;
      t_avg = update_channel(0, int'($signed(s.temp_sample)));
      c_avg = update_channel(1, int'($signed(s.charge_sample)));
      slot = (slot + 1) % AVG_DEPTH;
      e.temp_min   = 16'(lo[0]);
      e.temp_max   = 16'(hi[0]);
      e.temp_avg   = 16'(t_avg);
      e.charge_min = 16'(lo[1]);
      e.charge_max = 16'(hi[1]);
      e.charge_avg = 16'(c_avg);
      expected_stats.push_back(e);
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        mismatch_count++;
        $display("%0t: %s expected %0d (0x%04h), got %0d (0x%04h)", $time, name,
                 $signed(exp_v), exp_v, $signed(act_v), act_v);
      end
    endfunction

    function void check_stats(out_t r);
      out_t e;
      if (expected_stats.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, got 0x%024h", $time, r);
        return;
      end
      e = expected_stats.pop_front();
      compare_field("temp_min", e.temp_min, r.temp_min);
      compare_field("temp_max", e.temp_max, r.temp_max);
      compare_field("temp_avg", e.temp_avg, r.temp_avg);
      compare_field("charge_min", e.charge_min, r.charge_min);
      compare_field("charge_max", e.charge_max, r.charge_max);
      compare_field("charge_avg", e.charge_avg, r.charge_avg);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  int idle_pct;
  int stall_pct;
  min_max_avg_tracker stats;

  dual_moving_average_min_max_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // One process notes accepted inputs and checks accepted results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) stats.check_stats(out_data);
      if (in_valid && !in_stall) stats.take_sample(in_data);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pair(input logic [15:0] t, input logic [15:0] c);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.temp_sample = t;
    in_data.charge_sample = c;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return 16'($urandom_range(512) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    stats = new();
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // warm-up: zeros in the window, temp min and charge max stay at zero
    for (int k = 1; k <= 6; k++) send_pair(16'(100 * k), 16'(-100 * k));
    // full-scale windows in both directions
    repeat (AVG_DEPTH) send_pair(16'h7fff, 16'h8000);
    repeat (AVG_DEPTH) send_pair(16'h8000, 16'h7fff);
    send_pair(16'h0000, 16'hffff);
    send_pair(16'hffff, 16'h0001);
    send_pair(16'h0001, 16'h0000);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      for (int n = 0; n < 140; n++) begin
        if ($urandom_range(29) == 0) begin
          // a run of one extreme value fills the window
          if ($urandom_range(1) == 1) repeat (AVG_DEPTH) send_pair(16'h7fff, 16'h8000);
          else repeat (AVG_DEPTH) send_pair(16'h8000, 16'h7fff);
        end else begin
          send_pair(random_sample(), random_sample());
        end
      end
    end
    in_valid = 1'b0;

    while (stats.expected_stats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (stats.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dmam_pkg.sv
rtl/dmam_ram.sv
rtl/dmam_chan.sv
rtl/dual_moving_average_min_max_top.sv
rtl/dmam_checker.sv
test/tb.sv
